// ===== rtl/core/ipfem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP forward exact match engine package
// Shared sizes, codes and helpers for the forwarding engine and its tables.
// ----------------------------------------------------------------------------
package ipfem_pkg;

  localparam int ROUTE_ENTRIES_DEF = 16;
  localparam int ARP_ENTRIES_DEF   = 16;

  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int MAC_W    = 48;
  localparam int TTL_W    = 8;
  localparam int ACT_W    = 2;
  localparam int VERD_W   = 3;
  localparam int RREC_W   = 1 + PORT_W + IP_W;

  localparam logic [MAC_W-1:0] BROADCAST_MAC = {MAC_W{1'b1}};

  localparam logic [ACT_W-1:0] ACT_PACKET = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ARP    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DOWN   = 2'd3;

  localparam logic [VERD_W-1:0] V_FWD     = 3'd0;
  localparam logic [VERD_W-1:0] V_DELIVER = 3'd1;
  localparam logic [VERD_W-1:0] V_TTL     = 3'd2;
  localparam logic [VERD_W-1:0] V_NOROUTE = 3'd3;
  localparam logic [VERD_W-1:0] V_DONE    = 3'd4;
  localparam logic [VERD_W-1:0] V_FULL    = 3'd5;

  function automatic int idx_width(input int n);
    int w;
    w = (n > 1) ? $clog2(n) : 1;
    return w;
  endfunction

endpackage

// ===== rtl/core/ipfem_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP forward engine table
// Keyed table with per-entry valid flags and one registered read port.
// ----------------------------------------------------------------------------
module ipfem_table import ipfem_pkg::*; #(
  parameter int DEPTH  = ROUTE_ENTRIES_DEF,
  parameter int KEY_W  = IP_W,
  parameter int DATA_W = RREC_W,
  localparam int AW    = idx_width(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [AW-1:0]     rd_addr,
  output logic              rd_valid,
  output logic [KEY_W-1:0]  rd_key,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [KEY_W-1:0]  wr_key,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DEPTH-1:0]  valid_r;
  logic [KEY_W-1:0]  key_mem_r  [DEPTH];
  logic [DATA_W-1:0] data_mem_r [DEPTH];
  logic              rd_valid_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr]  <= wr_key;
      data_mem_r[wr_addr] <= wr_data;
    end
    rd_key_r  <= key_mem_r[rd_addr];
    rd_data_r <= data_mem_r[rd_addr];
  end

  assign rd_valid = rd_valid_r;
  assign rd_key   = rd_key_r;
  assign rd_data  = rd_data_r;

endmodule

// ===== rtl/core/ip_forward_exact_match_engine.sv =====
`timescale 1ns / 1ps
// Table requests and forwarded packets sweep one shared 32-bit comparator over each
// table in turn; a TTL drop or local delivery needs no sweep.
// One request is processed at a time; a new request is taken in the cycle after the
// previous result is queued. Synchronous active-low reset clears all valid flags,
// own_ip and the sequencer; table contents are not cleared.
// ----------------------------------------------------------------------------
// IP forward exact match engine
// Forwarding decision and route/ARP table maintenance with a sequential
// table sweep through a single shared address comparator.
// ----------------------------------------------------------------------------
module ip_forward_exact_match_engine import ipfem_pkg::*; #(
  parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
  parameter int ARP_ENTRIES   = ARP_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IP_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [IP_W-1:0]   in_dest_ip,
  input  logic [TTL_W-1:0]  in_ttl,
  input  logic [IP_W-1:0]   in_next_hop_ip,
  input  logic [PORT_W-1:0] in_out_port,
  input  logic [MAC_W-1:0]  in_mac_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VERD_W-1:0] out_verdict,
  output logic [PORT_W-1:0] out_fwd_port,
  output logic [IP_W-1:0]   out_fwd_next_hop,
  output logic [MAC_W-1:0]  out_fwd_mac,
  output logic              out_mac_resolved,
  output logic [TTL_W-1:0]  out_ttl_out
);

  localparam int MAX_ENT = (ROUTE_ENTRIES > ARP_ENTRIES) ? ROUTE_ENTRIES : ARP_ENTRIES;
  localparam int IDX_W   = idx_width(MAX_ENT);
  localparam int CNT_W   = $clog2(MAX_ENT + 1);
  localparam int RI_W    = idx_width(ROUTE_ENTRIES);
  localparam int AI_W    = idx_width(ARP_ENTRIES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RSCAN = 4'd2;
  localparam logic [3:0] S_RREC  = 4'd3;
  localparam logic [3:0] S_RUSE  = 4'd4;
  localparam logic [3:0] S_ASCAN = 4'd5;
  localparam logic [3:0] S_AREC  = 4'd6;
  localparam logic [3:0] S_AUSE  = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [IP_W-1:0]   own_ip_r;
  logic [ACT_W-1:0]  action_r, action_nxt;
  logic [IP_W-1:0]   dest_r, dest_nxt;
  logic [TTL_W-1:0]  ttl_r, ttl_nxt;
  logic [IP_W-1:0]   nh_r, nh_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [IP_W-1:0]   skey_r, skey_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;

  logic [VERD_W-1:0] res_verdict_r, res_verdict_nxt;
  logic [PORT_W-1:0] res_port_r, res_port_nxt;
  logic [IP_W-1:0]   res_nh_r, res_nh_nxt;
  logic [MAC_W-1:0]  res_mac_r, res_mac_nxt;
  logic              res_resolved_r, res_resolved_nxt;
  logic [TTL_W-1:0]  res_ttl_r, res_ttl_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [VERD_W-1:0] out_verdict_r;
  logic [PORT_W-1:0] out_port_r;
  logic [IP_W-1:0]   out_nh_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic              out_resolved_r;
  logic [TTL_W-1:0]  out_ttl_r;
  logic              out_load;

  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              rt_we, arp_we;
  logic [RREC_W-1:0] rt_wdata;
  logic              rt_q_valid, arp_q_valid;
  logic [IP_W-1:0]   rt_q_key, arp_q_key;
  logic [RREC_W-1:0] rt_q_data;
  logic [MAC_W-1:0]  arp_q_data;

  logic [IP_W-1:0]   cmp_a, cmp_b;
  logic              cmp_eq;
  logic              scanning;
  logic [CNT_W-1:0]  scan_n;
  logic              scan_issue;
  logic              scan_last;
  logic              q_valid;

  ipfem_table #(
    .DEPTH  (ROUTE_ENTRIES),
    .KEY_W  (IP_W),
    .DATA_W (RREC_W)
  ) u_route (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_idx[RI_W-1:0]),
    .rd_valid (rt_q_valid),
    .rd_key   (rt_q_key),
    .rd_data  (rt_q_data),
    .wr_en    (rt_we),
    .wr_addr  (wr_idx[RI_W-1:0]),
    .wr_key   (dest_r),
    .wr_data  (rt_wdata)
  );

  ipfem_table #(
    .DEPTH  (ARP_ENTRIES),
    .KEY_W  (IP_W),
    .DATA_W (MAC_W)
  ) u_arp (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_idx[AI_W-1:0]),
    .rd_valid (arp_q_valid),
    .rd_key   (arp_q_key),
    .rd_data  (arp_q_data),
    .wr_en    (arp_we),
    .wr_addr  (wr_idx[AI_W-1:0]),
    .wr_key   (nh_r),
    .wr_data  (mac_r)
  );

  assign scanning   = (state_r == S_RSCAN) || (state_r == S_ASCAN);
  assign scan_n     = (state_r == S_ASCAN) ? CNT_W'(ARP_ENTRIES) : CNT_W'(ROUTE_ENTRIES);
  assign scan_issue = scanning && (cnt_r < scan_n);
  assign scan_last  = cmp_vld_r && (cmp_idx_r == IDX_W'(scan_n - CNT_W'(1)));
  assign rd_idx     = scan_issue ? cnt_r[IDX_W-1:0] : hit_idx_r;
  assign q_valid    = (state_r == S_ASCAN) ? arp_q_valid : rt_q_valid;

  assign cmp_a  = (state_r == S_CHECK) ? dest_r :
                  (state_r == S_ASCAN) ? arp_q_key : rt_q_key;
  assign cmp_b  = (state_r == S_CHECK) ? own_ip_r : skey_r;
  assign cmp_eq = (cmp_a == cmp_b);

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt        = state_r;
    action_nxt       = action_r;
    dest_nxt         = dest_r;
    ttl_nxt          = ttl_r;
    nh_nxt           = nh_r;
    port_nxt         = port_r;
    mac_nxt          = mac_r;
    skey_nxt         = skey_r;
    cnt_nxt          = cnt_r;
    cmp_vld_nxt      = 1'b0;
    cmp_idx_nxt      = cmp_idx_r;
    hit_nxt          = hit_r;
    hit_idx_nxt      = hit_idx_r;
    free_nxt         = free_r;
    free_idx_nxt     = free_idx_r;
    res_verdict_nxt  = res_verdict_r;
    res_port_nxt     = res_port_r;
    res_nh_nxt       = res_nh_r;
    res_mac_nxt      = res_mac_r;
    res_resolved_nxt = res_resolved_r;
    res_ttl_nxt      = res_ttl_r;
    out_valid_nxt    = out_valid_r && out_stall;
    rt_we            = 1'b0;
    arp_we           = 1'b0;
    wr_idx           = hit_r ? hit_idx_r : free_idx_r;
    rt_wdata         = {1'b1, port_r, nh_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt       = in_action;
          dest_nxt         = in_dest_ip;
          ttl_nxt          = in_ttl;
          nh_nxt           = in_next_hop_ip;
          port_nxt         = in_out_port;
          mac_nxt          = in_mac_addr;
          cnt_nxt          = '0;
          hit_nxt          = 1'b0;
          free_nxt         = 1'b0;
          res_verdict_nxt  = V_DONE;
          res_port_nxt     = '0;
          res_nh_nxt       = '0;
          res_mac_nxt      = '0;
          res_resolved_nxt = 1'b0;
          res_ttl_nxt      = '0;
          unique case (in_action)
            ACT_PACKET: state_nxt = S_CHECK;
            ACT_ARP: begin
              skey_nxt  = in_next_hop_ip;
              state_nxt = S_ASCAN;
            end
            default: begin
              skey_nxt  = in_dest_ip;
              state_nxt = S_RSCAN;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (ttl_r[TTL_W-1:1] == '0) begin
          res_verdict_nxt = V_TTL;
          state_nxt       = S_OUT;
        end else if (cmp_eq) begin
          res_verdict_nxt = V_DELIVER;
          res_ttl_nxt     = ttl_r - TTL_W'(1);
          state_nxt       = S_OUT;
        end else begin
          skey_nxt  = dest_r;
          state_nxt = S_RSCAN;
        end
      end
      S_RSCAN, S_ASCAN: begin
        if (scan_issue) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = cnt_r[IDX_W-1:0];
        end
        if (cmp_vld_r && q_valid && cmp_eq && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
        end
        if (cmp_vld_r && !q_valid && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (scan_last) begin
          cnt_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          if (action_r == ACT_PACKET) begin
            if (state_r == S_RSCAN) begin
              if (hit_nxt) begin
                state_nxt = S_RREC;
              end else begin
                res_verdict_nxt = V_NOROUTE;
                state_nxt       = S_OUT;
              end
            end else if (hit_nxt) begin
              state_nxt = S_AREC;
            end else begin
              res_mac_nxt = BROADCAST_MAC;
              state_nxt   = S_OUT;
            end
          end else if (action_r == ACT_DOWN) begin
            state_nxt = hit_nxt ? S_RREC : S_OUT;
          end else if (hit_nxt || free_nxt) begin
            state_nxt = S_WR;
          end else begin
            res_verdict_nxt = V_FULL;
            state_nxt       = S_OUT;
          end
        end
      end
      S_RREC: state_nxt = S_RUSE;
      S_RUSE: begin
        if (action_r == ACT_PACKET) begin
          if (!rt_q_data[RREC_W-1]) begin
            res_verdict_nxt = V_NOROUTE;
            state_nxt       = S_OUT;
          end else begin
            res_verdict_nxt = V_FWD;
            res_port_nxt    = rt_q_data[PORT_W+IP_W-1:IP_W];
            res_nh_nxt      = rt_q_data[IP_W-1:0];
            res_ttl_nxt     = ttl_r - TTL_W'(1);
            skey_nxt        = rt_q_data[IP_W-1:0];
            hit_nxt         = 1'b0;
            free_nxt        = 1'b0;
            state_nxt       = S_ASCAN;
          end
        end else begin
          rt_we     = 1'b1;
          wr_idx    = hit_idx_r;
          rt_wdata  = {1'b0, rt_q_data[RREC_W-2:0]};
          state_nxt = S_OUT;
        end
      end
      S_AREC: state_nxt = S_AUSE;
      S_AUSE: begin
        res_mac_nxt      = arp_q_data;
        res_resolved_nxt = 1'b1;
        state_nxt        = S_OUT;
      end
      S_WR: begin
        rt_we     = (action_r == ACT_ADD);
        arp_we    = (action_r == ACT_ARP);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      own_ip_r    <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        own_ip_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    action_r       <= action_nxt;
    dest_r         <= dest_nxt;
    ttl_r          <= ttl_nxt;
    nh_r           <= nh_nxt;
    port_r         <= port_nxt;
    mac_r          <= mac_nxt;
    skey_r         <= skey_nxt;
    cmp_idx_r      <= cmp_idx_nxt;
    hit_idx_r      <= hit_idx_nxt;
    free_idx_r     <= free_idx_nxt;
    res_verdict_r  <= res_verdict_nxt;
    res_port_r     <= res_port_nxt;
    res_nh_r       <= res_nh_nxt;
    res_mac_r      <= res_mac_nxt;
    res_resolved_r <= res_resolved_nxt;
    res_ttl_r      <= res_ttl_nxt;
    if (out_load) begin
      out_verdict_r  <= res_verdict_r;
      out_port_r     <= res_port_r;
      out_nh_r       <= res_nh_r;
      out_mac_r      <= res_mac_r;
      out_resolved_r <= res_resolved_r;
      out_ttl_r      <= res_ttl_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_fwd_port     = out_port_r;
  assign out_fwd_next_hop = out_nh_r;
  assign out_fwd_mac      = out_mac_r;
  assign out_mac_resolved = out_resolved_r;
  assign out_ttl_out      = out_ttl_r;

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result queued outside the output state");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_verdict_r <= V_FULL)
    else $error("verdict code out of range");

  a_nonfwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r != V_FWD) |->
      (out_port_r == '0 && out_nh_r == '0 && out_mac_r == '0 && !out_resolved_r))
    else $error("non-forwarded result carries forwarding fields");

  a_broadcast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r == V_FWD && !out_resolved_r) |->
      out_mac_r == BROADCAST_MAC)
    else $error("unresolved forward without broadcast address");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scanning |-> cnt_r <= scan_n)
    else $error("table sweep counter past table depth");

endmodule
